// ===== hw/rtl/palette_quantize_error_diffusion_core_assert.svh =====
// Assertion macros shared by the palette quantizer RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef PALETTE_QUANTIZE_ERROR_DIFFUSION_CORE_ASSERT_SVH
`define PALETTE_QUANTIZE_ERROR_DIFFUSION_CORE_ASSERT_SVH

// Same-cycle implication.
`define PQED_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pqed assertion failed");

// Next-cycle implication.
`define PQED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pqed assertion failed");

`endif

// ===== hw/rtl/pqed_pkg.sv =====
// Package for the palette quantizer: sizes, commands, job record and helpers.
// No dependencies; the core, front, back and testbench import it.
`timescale 1ns / 1ps

package pqed_pkg;

  localparam int MAX_WIDTH       = 1024;
  localparam int PALETTE_ENTRIES = 228;

  localparam int CFG_W    = 11;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WE_W     = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam int LS_AW    = COL_W + 1;
  localparam int LS_DEPTH = 2 * MAX_WIDTH;
  localparam int PAL_AW   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int PAL_CW   = $clog2(PALETTE_ENTRIES + 1);
  localparam int PIDX_W   = 8;
  localparam int DIST_W   = 18;
  localparam int ROOT_W   = 9;

  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(320);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    cmd_t              kind;
    logic [PIDX_W-1:0] idx;
    rgba_t             pix;
    logic [COL_W-1:0]  col;
    logic              sel;
    logic              q_left;
    logic              q_last;
  } job_t;

  function automatic logic [7:0] scale_raw(input logic [7:0] v);
    return (v < 8'd64) ? {v[5:0], 2'b00} : v;
  endfunction

  function automatic logic [7:0] abs9(input logic signed [8:0] v);
    logic [8:0] m;
    m = v[8] ? 9'(-v) : 9'(v);
    return m[7:0];
  endfunction

  // Adds err*f/16 (truncated toward zero) to a stored channel and clamps.
  function automatic logic [7:0] spread_ch(input logic [7:0] s,
                                           input logic signed [8:0] e,
                                           input logic [2:0] f);
    logic signed [12:0] prod;
    logic [12:0]        mag;
    logic [8:0]         shr;
    logic [10:0]        sum;
    prod = $signed({{4{e[8]}}, e}) * $signed({10'd0, f});
    mag  = prod[12] ? 13'(-prod) : 13'(prod);
    shr  = mag[12:4];
    sum  = prod[12] ? ({3'b000, s} - {2'b00, shr}) : ({3'b000, s} + {2'b00, shr});
    if (sum[10]) return 8'd0;
    if (sum[9:8] != 2'b00) return 8'd255;
    return sum[7:0];
  endfunction

endpackage

// ===== hw/rtl/pqed_if.sv =====
// Valid/ready stream interfaces for the input items and the results.
// Depends on pqed_pkg for field widths.
`timescale 1ns / 1ps

interface pqed_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [pqed_pkg::PIDX_W-1:0] entry_index;
  logic [7:0]                red;
  logic [7:0]                green;
  logic [7:0]                blue;
  logic [7:0]                alpha;
  modport source (output valid, cmd, entry_index, red, green, blue, alpha, input ready);
  modport sink   (input valid, cmd, entry_index, red, green, blue, alpha, output ready);
endinterface

interface pqed_out_if;
  logic                        valid;
  logic                        ready;
  logic [pqed_pkg::PIDX_W-1:0] palette_index;
  logic                        row_end;
  modport source (output valid, palette_index, row_end, input ready);
  modport sink   (input valid, palette_index, row_end, output ready);
endinterface

// ===== hw/rtl/palette_quantize_error_diffusion_core.sv =====
// Top level of the palette quantizer with error diffusion.
// Depends on pqed_pkg, pqed_if, pqed_front and pqed_back.
`timescale 1ns / 1ps
//
// Usage: input beats on "item" carry a command: load a palette entry, push a
// pixel in raster order, or drain one pixel of the final row. Results on
// "result" give the chosen palette entry and a flag for the last pixel of a
// row. The row width is written through wr_en/wr_data while the block idles;
// a write restarts the image.
// The front accepts one beat per cycle into a two-job queue while the queue
// has room. The back handles one job at a time; a load or pixel store is
// written as its job is popped. Each quantized pixel reads its stored value,
// scans all palette entries through one distance unit at one entry per cycle,
// pausing for the square root and a restart for every entry that improves on
// the best so far (the first entry always does), then computes the error,
// spreads it (one read and one write per neighbor) and emits the result.
// A pixel beat causes zero, one or two quantizes.
// Reset clears the raster position and queue and sets the width to 320;
// palette and line store keep their contents, and unwritten entries are
// undefined. When the receiver stalls, one result waits in the output register
// and the back holds; the queue then fills and the front deasserts ready.

module palette_quantize_error_diffusion_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [pqed_pkg::CFG_W-1:0] wr_data,
  pqed_in_if.sink                    item,
  pqed_out_if.source                 result
);
  import pqed_pkg::*;

  logic [WE_W-1:0] width_eff;
  logic            q_valid;
  job_t            q_job;
  logic            q_pop;

  pqed_front u_front (
    .clk, .rst, .wr_en, .wr_data, .item,
    .width_eff, .q_valid, .q_job, .q_pop
  );

  pqed_back u_back (
    .clk, .rst, .width_eff, .q_valid, .q_job, .q_pop, .result
  );
endmodule

// ===== hw/rtl/pqed_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pqed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/pqed_front.sv =====
// Front end: takes input beats, tracks raster position, and queues jobs.
// Depends on pqed_pkg and pqed_if; holds the frame width register.
`timescale 1ns / 1ps

module pqed_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [pqed_pkg::CFG_W-1:0] wr_data,
  pqed_in_if.sink                   item,
  output logic [pqed_pkg::WE_W-1:0] width_eff,
  output logic                      q_valid,
  output pqed_pkg::job_t            q_job,
  input  logic                      q_pop
);
  import pqed_pkg::*;

  logic [CFG_W-1:0] row_width;
  logic [COL_W-1:0] arrive_column;
  logic [COL_W-1:0] drain_column;
  logic             prior_row_valid;
  logic             cur_sel;

  job_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  logic             accept;
  logic             push;
  job_t             job_new;
  logic [COL_W-1:0] arrive_next;
  logic [COL_W-1:0] drain_next;
  logic             prior_next;
  logic             sel_next;
  logic [COL_W-1:0] arr0;
  logic             prv0;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] dcol;
  logic             last;

  always_comb begin
    if (row_width == '0) begin
      width_eff = WE_W'(1);
    end else if (WE_W'(row_width) > WE_W'(MAX_WIDTH)) begin
      width_eff = WE_W'(MAX_WIDTH);
    end else begin
      width_eff = WE_W'(row_width);
    end
  end

  assign item.ready = (count != 2'd2);
  assign accept     = item.valid && item.ready;
  assign q_valid    = (count != 2'd0);
  assign q_job      = fifo[rd_ptr];

  always_comb begin
    push           = 1'b0;
    arrive_next    = arrive_column;
    drain_next     = drain_column;
    prior_next     = prior_row_valid;
    sel_next       = cur_sel;
    job_new.kind   = cmd_t'(item.cmd);
    job_new.idx    = item.entry_index;
    job_new.pix    = '{r: item.red, g: item.green, b: item.blue, a: item.alpha};
    job_new.col    = '0;
    job_new.sel    = cur_sel;
    job_new.q_left = 1'b0;
    job_new.q_last = 1'b0;
    // A pixel after a partial drain restarts the image.
    arr0 = (drain_column != '0) ? '0 : arrive_column;
    prv0 = (drain_column != '0) ? 1'b0 : prior_row_valid;
    col  = (WE_W'(arr0) >= width_eff) ? '0 : arr0;
    dcol = (WE_W'(drain_column) >= width_eff) ? '0 : drain_column;
    last = 1'b0;
    case (cmd_t'(item.cmd))
      CMD_LOAD: begin
        push        = (WE_W'(item.entry_index) < WE_W'(PALETTE_ENTRIES));
        job_new.pix = '{r: scale_raw(item.red), g: scale_raw(item.green),
                        b: scale_raw(item.blue), a: 8'd0};
      end
      CMD_PIXEL: begin
        push           = 1'b1;
        last           = (WE_W'(col) == width_eff - WE_W'(1));
        job_new.col    = col;
        job_new.q_left = prv0 && (col != '0);
        job_new.q_last = prv0 && last;
        drain_next     = '0;
        if (last) begin
          arrive_next = '0;
          sel_next    = ~cur_sel;
          prior_next  = 1'b1;
        end else begin
          arrive_next = col + COL_W'(1);
          prior_next  = prv0;
        end
      end
      CMD_DRAIN: begin
        if (prior_row_valid && (arrive_column == '0)) begin
          push           = 1'b1;
          last           = (WE_W'(dcol) == width_eff - WE_W'(1));
          job_new.col    = dcol;
          job_new.q_last = 1'b1;
          if (last) begin
            drain_next = '0;
            prior_next = 1'b0;
          end else begin
            drain_next = dcol + COL_W'(1);
          end
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width       <= WIDTH_RESET;
      arrive_column   <= '0;
      drain_column    <= '0;
      prior_row_valid <= 1'b0;
      cur_sel         <= 1'b0;
    end else if (wr_en) begin
      row_width       <= wr_data;
      arrive_column   <= '0;
      drain_column    <= '0;
      prior_row_valid <= 1'b0;
    end else if (accept) begin
      arrive_column   <= arrive_next;
      drain_column    <= drain_next;
      prior_row_valid <= prior_next;
      cur_sel         <= sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept && push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(accept && push) - 2'(q_pop && q_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push) begin
      fifo[wr_ptr] <= job_new;
    end
  end
endmodule

// ===== hw/rtl/pqed_back.sv =====
// Back end: palette and line stores, nearest-entry search and error spread.
// Depends on pqed_pkg, pqed_if, pqed_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "palette_quantize_error_diffusion_core_assert.svh"

module pqed_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [pqed_pkg::WE_W-1:0] width_eff,
  input  logic                      q_valid,
  input  pqed_pkg::job_t            q_job,
  output logic                      q_pop,
  pqed_out_if.source                result
);
  import pqed_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_DISP  = 11'b00000000010,
    ST_PREAD = 11'b00000000100,
    ST_PWAIT = 11'b00000001000,
    ST_SCAN  = 11'b00000010000,
    ST_SQRT  = 11'b00000100000,
    ST_SQ    = 11'b00001000000,
    ST_ERR   = 11'b00010000000,
    ST_SPRD  = 11'b00100000000,
    ST_SPWR  = 11'b01000000000,
    ST_EMIT  = 11'b10000000000
  } state_t;

  state_t st;

  // Current job.
  logic             j_sel;
  logic [COL_W-1:0] j_col;
  logic             j_below;
  logic             pend_left;
  logic             pend_last;
  logic [COL_W-1:0] qcol;

  // Search state.
  rgba_t             p;
  logic [PAL_CW-1:0] rd_idx;
  logic              s1_v;
  logic [PAL_CW-1:0] s1_idx;
  logic              s2_v;
  logic [PAL_CW-1:0] s2_idx;
  logic [DIST_W-1:0] s2_d;
  logic [23:0]       s2_rgb;
  logic              have;
  logic [PAL_CW-1:0] best;
  logic [23:0]       best_rgb;
  logic [DIST_W-1:0] sq;
  logic [DIST_W-1:0] sr_v;
  logic [DIST_W-1:0] sr_root;
  logic [DIST_W-1:0] sr_bit;

  // Spread state.
  logic signed [8:0] e_r, e_g, e_b, e_a;
  logic [2:0]        tgt;
  logic [LS_AW-1:0]  sp_addr;
  logic [2:0]        sp_f;

  // Memory ports.
  logic              pal_we;
  logic [PAL_AW-1:0] pal_waddr;
  logic [23:0]       pal_wdata;
  logic [23:0]       pal_rdata;
  logic              ls_we;
  logic [LS_AW-1:0]  ls_waddr;
  logic [31:0]       ls_wdata;
  logic [LS_AW-1:0]  ls_raddr;
  logic [31:0]       ls_rdata;

  logic [DIST_W-1:0] d_sum;
  logic              better;
  logic              t_en;
  logic [LS_AW-1:0]  t_addr;
  logic [2:0]        t_f;
  logic              right_ok;
  logic [DIST_W-1:0] sr_try;
  rgba_t             old_px;
  rgba_t             new_px;
  logic              emit_go;

  pqed_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_pal (
    .clk, .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
    .raddr(rd_idx[PAL_AW-1:0]), .rdata(pal_rdata)
  );

  pqed_ram #(.WIDTH(32), .DEPTH(LS_DEPTH)) u_line (
    .clk, .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
    .raddr(ls_raddr), .rdata(ls_rdata)
  );

  assign q_pop     = (st == ST_IDLE) && q_valid;
  assign pal_we    = q_pop && (q_job.kind == CMD_LOAD);
  assign pal_waddr = q_job.idx[PAL_AW-1:0];
  assign pal_wdata = {q_job.pix.r, q_job.pix.g, q_job.pix.b};

  always_comb begin
    d_sum = DIST_W'(abs9($signed({1'b0, p.r}) - $signed({1'b0, pal_rdata[23:16]})) ** 2)
          + DIST_W'(abs9($signed({1'b0, p.g}) - $signed({1'b0, pal_rdata[15:8]})) ** 2)
          + DIST_W'(abs9($signed({1'b0, p.b}) - $signed({1'b0, pal_rdata[7:0]})) ** 2)
          + DIST_W'(p.a * p.a);
  end

  // floor(sqrt(d)) < floor(sqrt(best)) exactly when d < floor(sqrt(best))^2.
  assign better   = !have || (s2_d < sq);
  assign right_ok = (WE_W'(qcol) + WE_W'(1)) < width_eff;
  assign sr_try   = sr_root + sr_bit;
  assign emit_go  = (st == ST_EMIT) && (!result.valid || result.ready);

  always_comb begin
    t_en   = 1'b0;
    t_addr = {~j_sel, qcol + COL_W'(1)};
    t_f    = 3'd7;
    case (tgt)
      3'd0: begin
        t_en   = right_ok;
        t_addr = {~j_sel, qcol + COL_W'(1)};
        t_f    = 3'd7;
      end
      3'd1: begin
        t_en   = j_below && (qcol != '0);
        t_addr = {j_sel, qcol - COL_W'(1)};
        t_f    = 3'd3;
      end
      3'd2: begin
        t_en   = j_below;
        t_addr = {j_sel, qcol};
        t_f    = 3'd5;
      end
      3'd3: begin
        t_en   = j_below && right_ok;
        t_addr = {j_sel, qcol + COL_W'(1)};
        t_f    = 3'd1;
      end
      default: begin
        t_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    old_px   = rgba_t'(ls_rdata);
    new_px.r = spread_ch(old_px.r, e_r, sp_f);
    new_px.g = spread_ch(old_px.g, e_g, sp_f);
    new_px.b = spread_ch(old_px.b, e_b, sp_f);
    new_px.a = spread_ch(old_px.a, e_a, sp_f);
    if (st == ST_SPWR) begin
      ls_we    = 1'b1;
      ls_waddr = sp_addr;
      ls_wdata = new_px;
    end else begin
      ls_we    = q_pop && (q_job.kind == CMD_PIXEL);
      ls_waddr = {q_job.sel, q_job.col};
      ls_wdata = q_job.pix;
    end
    ls_raddr = (st == ST_PREAD) ? {~j_sel, qcol} : t_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit_go) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      have         <= 1'b0;
      pend_left    <= 1'b0;
      pend_last    <= 1'b0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (q_valid) begin
            j_sel     <= q_job.sel;
            j_col     <= q_job.col;
            j_below   <= (q_job.kind == CMD_PIXEL);
            pend_left <= (q_job.kind != CMD_LOAD) && q_job.q_left;
            pend_last <= (q_job.kind != CMD_LOAD) && q_job.q_last;
            st        <= ST_DISP;
          end
        end
        ST_DISP: begin
          if (pend_left) begin
            pend_left <= 1'b0;
            qcol      <= j_col - COL_W'(1);
            st        <= ST_PREAD;
          end else if (pend_last) begin
            pend_last <= 1'b0;
            qcol      <= j_col;
            st        <= ST_PREAD;
          end else begin
            st <= ST_IDLE;
          end
        end
        ST_PREAD: begin
          st <= ST_PWAIT;
        end
        ST_PWAIT: begin
          p      <= rgba_t'(ls_rdata);
          rd_idx <= '0;
          have   <= 1'b0;
          s1_v   <= 1'b0;
          s2_v   <= 1'b0;
          st     <= ST_SCAN;
        end
        ST_SCAN: begin
          if (s2_v && better) begin
            // New best: drop the beats in flight and resume after it.
            best     <= s2_idx;
            best_rgb <= s2_rgb;
            have     <= 1'b1;
            s1_v     <= 1'b0;
            s2_v     <= 1'b0;
            rd_idx   <= s2_idx + PAL_CW'(1);
            sr_v     <= s2_d;
            sr_root  <= '0;
            sr_bit   <= DIST_W'(1) << (DIST_W - 2);
            st       <= ST_SQRT;
          end else begin
            s2_v   <= s1_v;
            s2_idx <= s1_idx;
            s2_d   <= d_sum;
            s2_rgb <= pal_rdata;
            if (rd_idx < PAL_CW'(PALETTE_ENTRIES)) begin
              s1_v   <= 1'b1;
              s1_idx <= rd_idx;
              rd_idx <= rd_idx + PAL_CW'(1);
            end else begin
              s1_v <= 1'b0;
              if (!s1_v && !s2_v) begin
                st <= ST_ERR;
              end
            end
          end
        end
        ST_SQRT: begin
          if (sr_v >= sr_try) begin
            sr_v    <= sr_v - sr_try;
            sr_root <= (sr_root >> 1) + sr_bit;
          end else begin
            sr_root <= sr_root >> 1;
          end
          sr_bit <= sr_bit >> 2;
          if (sr_bit == DIST_W'(1)) begin
            st <= ST_SQ;
          end
        end
        ST_SQ: begin
          sq <= DIST_W'(sr_root[ROOT_W-1:0] * sr_root[ROOT_W-1:0]);
          st <= ST_SCAN;
        end
        ST_ERR: begin
          e_r <= $signed({1'b0, p.r}) - $signed({1'b0, best_rgb[23:16]});
          e_g <= $signed({1'b0, p.g}) - $signed({1'b0, best_rgb[15:8]});
          e_b <= $signed({1'b0, p.b}) - $signed({1'b0, best_rgb[7:0]});
          e_a <= $signed({1'b0, p.a});
          tgt <= 3'd0;
          st  <= ST_SPRD;
        end
        ST_SPRD: begin
          if (tgt == 3'd4) begin
            st <= ST_EMIT;
          end else if (t_en) begin
            sp_addr <= t_addr;
            sp_f    <= t_f;
            st      <= ST_SPWR;
          end else begin
            tgt <= tgt + 3'd1;
          end
        end
        ST_SPWR: begin
          tgt <= tgt + 3'd1;
          st  <= ST_SPRD;
        end
        ST_EMIT: begin
          if (emit_go) begin
            result.palette_index <= PIDX_W'(best);
            result.row_end       <= (WE_W'(qcol) == width_eff - WE_W'(1));
            st                   <= ST_DISP;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  `PQED_ASSERT_IMPL(a_scan_idx_range, (st == ST_SCAN) && s2_v, s2_idx < PAL_CW'(PALETTE_ENTRIES))
  `PQED_ASSERT_IMPL(a_emit_has_best, st == ST_EMIT, have)
  `PQED_ASSERT_NEXT(a_write_follows_read, st == ST_SPWR, (st == ST_SPRD) && (tgt != 3'd0))
endmodule

// ===== tb/testbench.sv =====
// Testbench for palette_quantize_error_diffusion_core: a palette is loaded, then
// images are pushed and drained while a predictor checks every chosen entry.
// Depends on pqed_pkg, pqed_if and the core RTL.
`timescale 1ns / 1ps

import pqed_pkg::*;

class dither_scoreboard;
  typedef struct {
    logic [7:0] index;
    logic       last;
  } pick_t;

  byte unsigned palette[PALETTE_ENTRIES][3];
  byte unsigned lines[LS_DEPTH][4];
  int unsigned  arrive_col;
  int unsigned  drain_col;
  int unsigned  row_sel;
  int unsigned  width_reg;
  bit           prior_row;
  pick_t        picks_q[$];
  int           failures;

  function new();
    foreach (palette[i, j]) palette[i][j] = 0;
    foreach (lines[i, j]) lines[i][j] = 0;
    arrive_col = 0;
    drain_col  = 0;
    row_sel    = 0;
    prior_row  = 0;
    width_reg  = 320;
    failures   = 0;
  endfunction

  function void set_width(int unsigned v);
    width_reg  = v & 'h7ff;
    arrive_col = 0;
    drain_col  = 0;
    prior_row  = 0;
  endfunction

  function int unsigned cur_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function int unsigned floor_root(int unsigned v);
    int unsigned root;
    int unsigned bits;
    root = 0;
    bits = 1 << 30;
    while (bits > v) bits >>= 2;
    while (bits != 0) begin
      if (v >= root + bits) begin
        v -= root + bits;
        root = (root >> 1) + bits;
      end else begin
        root >>= 1;
      end
      bits >>= 2;
    end
    return root;
  endfunction

  // Adds a truncated share of the error to each channel and clamps.
  function void diffuse(int unsigned slot, int err[4], int factor);
    int t;
    for (int ch = 0; ch < 4; ch++) begin
      t = int'(lines[slot][ch]) + (err[ch] * factor) / 16;
      if (t > 255) t = 255;
      if (t < 0) t = 0;
      lines[slot][ch] = 8'(t);
    end
  endfunction

  function void quantize(int unsigned half, int unsigned col, bit has_below,
                         int unsigned below);
    int unsigned w, base, bbase, best, best_d, d;
    int          dr, dg, db, da;
    int          err[4];
    pick_t       p;
    w = cur_width();
    base = half * MAX_WIDTH + col;
    bbase = below * MAX_WIDTH;
    best = 0;
    best_d = 32'hffff_ffff;
    for (int j = 0; j < PALETTE_ENTRIES; j++) begin
      dr = int'(lines[base][0]) - int'(palette[j][0]);
      dg = int'(lines[base][1]) - int'(palette[j][1]);
      db = int'(lines[base][2]) - int'(palette[j][2]);
      da = int'(lines[base][3]);
      d = floor_root(dr * dr + dg * dg + db * db + da * da);
      if (d < best_d) begin
        best_d = d;
        best = j;
      end
    end
    for (int ch = 0; ch < 3; ch++) err[ch] = int'(lines[base][ch]) - int'(palette[best][ch]);
    err[3] = int'(lines[base][3]);
    if (col + 1 < w) diffuse(base + 1, err, 7);
    if (has_below) begin
      if (col >= 1) diffuse(bbase + col - 1, err, 3);
      diffuse(bbase + col, err, 5);
      if (col + 1 < w) diffuse(bbase + col + 1, err, 1);
    end
    p.index = best[7:0];
    p.last  = (col == w - 1);
    picks_q.push_back(p);
  endfunction

  function byte unsigned scale(byte unsigned v);
    return (v < 64) ? byte'(v * 4) : v;
  endfunction

  function void note_item(cmd_t c, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                          logic [7:0] b, logic [7:0] a);
    int unsigned w, sel, other, col;
    w = cur_width();
    sel = row_sel & 1;
    other = sel ^ 1;
    case (c)
      CMD_LOAD: begin
        if (idx < PALETTE_ENTRIES) begin
          palette[idx][0] = scale(r);
          palette[idx][1] = scale(g);
          palette[idx][2] = scale(b);
        end
      end
      CMD_PIXEL: begin
        // A pixel arriving mid-drain starts a fresh image.
        if (drain_col != 0) begin
          drain_col = 0;
          prior_row = 0;
          arrive_col = 0;
        end
        if (arrive_col >= w) arrive_col = 0;
        col = arrive_col;
        lines[sel * MAX_WIDTH + col][0] = r;
        lines[sel * MAX_WIDTH + col][1] = g;
        lines[sel * MAX_WIDTH + col][2] = b;
        lines[sel * MAX_WIDTH + col][3] = a;
        if (prior_row) begin
          if (col >= 1) quantize(other, col - 1, 1, sel);
          if (col == w - 1) quantize(other, col, 1, sel);
        end
        if (col == w - 1) begin
          arrive_col = 0;
          row_sel = other;
          prior_row = 1;
        end else begin
          arrive_col = col + 1;
        end
      end
      CMD_DRAIN: begin
        if (prior_row && arrive_col == 0) begin
          if (drain_col >= w) drain_col = 0;
          quantize(other, drain_col, 0, sel);
          if (drain_col == w - 1) begin
            drain_col = 0;
            prior_row = 0;
          end else begin
            drain_col++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [7:0] index, logic last);
    pick_t p;
    if (picks_q.size() == 0) begin
      failures++;
      if (failures <= 10) $display("unexpected result: index %0d row_end %0d", index, last);
      return;
    end
    p = picks_q.pop_front();
    if (index !== p.index || last !== p.last) begin
      failures++;
      if (failures <= 10)
        $display("mismatch: expected index %0d row_end %0d, got index %0d row_end %0d",
                 p.index, p.last, index, last);
    end
  endfunction
endclass

module testbench;
  logic clk;
  logic rst;
  logic wr_en;
  logic [CFG_W-1:0] wr_data;
  int   accepted;
  int   received;
  bit   long_hold_done;
  bit   hold_request;
  dither_scoreboard sb;

  pqed_in_if  item_bus();
  pqed_out_if result_bus();

  palette_quantize_error_diffusion_core uut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_data(wr_data),
    .item(item_bus),
    .result(result_bus)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #1_000_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly short gaps, a few long; some stretches run with none at all.
  function automatic int pick_gap(int count);
    int roll;
    if ((count / 64) % 3 == 0) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [7:0] pick_chan();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  task automatic put_item(cmd_t c, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                          logic [7:0] b, logic [7:0] a);
    int gap;
    gap = pick_gap(accepted);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid       <= 1'b1;
    item_bus.cmd         <= c;
    item_bus.entry_index <= idx;
    item_bus.red         <= r;
    item_bus.green       <= g;
    item_bus.blue        <= b;
    item_bus.alpha       <= a;
    do @(posedge clk); while (!item_bus.ready);
    sb.note_item(c, idx, r, g, b, a);
    accepted++;
  endtask

  task automatic put_drain();
    put_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic put_pixel();
    put_item(CMD_PIXEL, 8'($urandom_range(255)), pick_chan(), pick_chan(), pick_chan(),
             pick_chan());
  endtask

  task automatic put_noise();
    case ($urandom_range(2))
      0: put_item(CMD_LOAD, 8'($urandom_range(255)), pick_chan(), pick_chan(), pick_chan(),
                  pick_chan());
      1: put_item(CMD_NONE, 8'($urandom_range(255)), pick_chan(), pick_chan(), pick_chan(),
                  pick_chan());
      default: put_item(CMD_DRAIN, 8'($urandom_range(255)), pick_chan(), pick_chan(),
                        pick_chan(), pick_chan());
    endcase
  endtask

  // The sender pauses until every result is in, lets the back finish any
  // store still in flight, then writes the width.
  task automatic write_width(logic [CFG_W-1:0] w);
    item_bus.valid <= 1'b0;
    while (sb.picks_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    wr_en   <= 1'b1;
    wr_data <= w;
    @(posedge clk);
    wr_en <= 1'b0;
    sb.set_width(w);
  endtask

  task automatic run_image(int unsigned rows);
    int unsigned w;
    int          roll;
    w = sb.cur_width();
    repeat (rows) begin
      repeat (w) begin
        if ($urandom_range(99) < 6) put_noise();
        put_pixel();
      end
    end
    roll = $urandom_range(99);
    if (roll < 70) begin
      repeat (w) put_drain();
    end else if (roll < 85) begin
      repeat ($urandom_range(w)) put_drain();
    end
  endtask

  // Receiver: random stalls, plus one long hold while the sender keeps going.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (result_bus.valid && result_bus.ready) begin
        sb.check_result(result_bus.palette_index, result_bus.row_end);
        received++;
      end
      if (hold_request && !long_hold_done) begin
        long_hold_done = 1;
        stall_left = 20000;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if ($urandom_range(99) < 15) stall_left = pick_gap(received + 64);
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] w;
    sb = new();
    accepted = 0;
    received = 0;
    long_hold_done = 0;
    hold_request = 0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_data = '0;
    item_bus.valid = 1'b0;
    item_bus.cmd = CMD_NONE;
    item_bus.entry_index = '0;
    item_bus.red = '0;
    item_bus.green = '0;
    item_bus.blue = '0;
    item_bus.alpha = '0;
    result_bus.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every entry is loaded before any pixel is matched.
    for (int i = 0; i < PALETTE_ENTRIES; i++)
      put_item(CMD_LOAD, 8'(i), pick_chan(), pick_chan(), pick_chan(), pick_chan());

    // Directed: stray drain, unknown command, out-of-range loads, extremes.
    write_width(CFG_W'(3));
    put_drain();
    put_item(CMD_NONE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    put_item(CMD_LOAD, 8'd228, 8'd1, 8'd2, 8'd3, 8'd4);
    put_item(CMD_LOAD, 8'd255, 8'd255, 8'd0, 8'd63, 8'd255);
    put_item(CMD_LOAD, 8'd227, 8'd63, 8'd64, 8'd0, 8'd9);
    put_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    put_item(CMD_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
    put_item(CMD_PIXEL, 8'd0, 8'd0, 8'd255, 8'd0, 8'd128);
    put_item(CMD_PIXEL, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
    put_drain();   // ignored: row partly received
    put_item(CMD_PIXEL, 8'd0, 8'd64, 8'd63, 8'd1, 8'd255);
    put_item(CMD_PIXEL, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0);
    put_drain();
    put_item(CMD_PIXEL, 8'd0, 8'd17, 8'd200, 8'd99, 8'd0);  // abandons the drain
    put_item(CMD_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
    put_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    repeat (3) put_drain();
    put_drain();   // ignored: nothing held

    write_width(CFG_W'(0));
    run_image(4);
    write_width(CFG_W'(1));
    run_image(5);

    // A width above the line store acts as the store width.
    write_width(CFG_W'(1100));
    repeat (3) put_pixel();

    // The receiver holds off while a whole image is offered, so the block fills.
    write_width(CFG_W'(8));
    hold_request = 1'b1;
    run_image(4);

    while (accepted < 460) begin
      w = ($urandom_range(99) < 15) ? CFG_W'($urandom_range(12, 9))
                                    : CFG_W'($urandom_range(6, 1));
      write_width(w);
      repeat ($urandom_range(2, 1)) run_image($urandom_range(5, 2));
    end
    item_bus.valid <= 1'b0;

    while (sb.picks_q.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (sb.failures == 0 && sb.picks_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pqed_pkg.sv
hw/rtl/pqed_if.sv
hw/rtl/pqed_ram.sv
hw/rtl/pqed_front.sv
hw/rtl/pqed_back.sv
hw/rtl/palette_quantize_error_diffusion_core.sv
tb/testbench.sv
